// ===== design/c2ut_pkg.sv =====
// Shared constants and types of the counter-to-unix-time converter.
package c2ut_pkg;

  localparam int unsigned CountW = 64;
  localparam int unsigned FreqW  = 32;
  localparam int unsigned UsecW  = 20;
  localparam int unsigned ProdW  = FreqW + UsecW;
  localparam int unsigned CntW   = $clog2(CountW);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [UsecW-1:0]  UsecPerSec = UsecW'(1000000);
  localparam logic [CountW-1:0] EpochReset = CountW'(64'd1771372800);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOOT  = 2'd0,
    REG_FREQ  = 2'd1,
    REG_EPOCH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_SEC,
    ST_DIV_US,
    ST_FIN
  } state_e;

endpackage

// ===== design/c2ut_if.sv =====
// Valid/ready channel interfaces for counter readings and converted times.
interface c2ut_in_if;
  logic                          valid;
  logic                          ready;
  logic [c2ut_pkg::CountW-1:0]   counter_now;

  modport source (output valid, output counter_now, input ready);
  modport sink   (input valid, input counter_now, output ready);
endinterface

interface c2ut_out_if;
  logic                          valid;
  logic                          ready;
  logic [c2ut_pkg::CountW-1:0]   timestamp;
  logic [c2ut_pkg::CountW-1:0]   unix_seconds;
  logic [c2ut_pkg::UsecW-1:0]    micro_seconds;
  logic                          updated;

  modport source (output valid, output timestamp, output unix_seconds,
                  output micro_seconds, output updated, input ready);
  modport sink   (input valid, input timestamp, input unix_seconds,
                  input micro_seconds, input updated, output ready);
endinterface

// ===== design/counter_to_unix_time.sv =====
// Top level of the counter-to-unix-time converter.

// Converts a 64-bit free-running counter reading into unix seconds and
// microseconds. Each transaction on the input channel yields exactly one
// transaction on the output channel: the reading is echoed as timestamp,
// unix_seconds is epoch_seconds + (reading - boot_count) / tick_frequency
// (both wrapping modulo 2^64), and micro_seconds is the remainder scaled by
// one million and divided by tick_frequency again. With tick_frequency at
// zero no conversion is made: the last converted time is returned with
// updated low. One item at a time is processed. A single restoring divider,
// one quotient bit per cycle, runs 64 steps for the seconds and 64 steps for
// the microseconds, with one step for the seconds add and remainder scaling
// between them and one step to load the result register. The result sits in
// an output register, so the next transaction is accepted while the previous
// result still waits to be taken. Configuration registers (0 boot_count, 1
// tick_frequency, 2 epoch_seconds) are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while the block is idle, which
// the block itself does not enforce. Index 3 is ignored.
module counter_to_unix_time (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  c2ut_in_if.sink                           in_if,
  c2ut_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [c2ut_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [c2ut_pkg::CountW-1:0]       cfg_data_i
);

  // Configuration registers
  logic [c2ut_pkg::CountW-1:0] boot_q, epoch_q;
  logic [c2ut_pkg::FreqW-1:0]  freq_q;

  // Held time state
  logic [c2ut_pkg::CountW-1:0] held_sec_q, held_sec_d;
  logic [c2ut_pkg::UsecW-1:0]  held_us_q, held_us_d;

  // Divider datapath: num_q carries the dividend in and the quotient out
  logic [c2ut_pkg::CountW-1:0] num_q, num_d;
  logic [c2ut_pkg::FreqW-1:0]  rem_q, rem_d;
  logic [c2ut_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [c2ut_pkg::CountW-1:0] ts_q, ts_d;
  logic                        upd_q, upd_d;

  // Output register
  logic                        out_vld_q, out_vld_d;
  logic [c2ut_pkg::CountW-1:0] out_ts_q, out_sec_q;
  logic [c2ut_pkg::UsecW-1:0]  out_us_q;
  logic                        out_upd_q;

  c2ut_pkg::state_e state_q, state_d;

  // Control strobes
  logic in_acc, div_step, div_last, sec_step, load_out;

  // Divider step signals
  logic [c2ut_pkg::FreqW:0]    shl;
  logic [c2ut_pkg::FreqW:0]    diff;
  logic                        ge;
  logic [c2ut_pkg::ProdW-1:0]  prod;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q  <= '0;
      freq_q  <= '0;
      epoch_q <= c2ut_pkg::EpochReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c2ut_pkg::REG_BOOT:  boot_q  <= cfg_data_i;
        c2ut_pkg::REG_FREQ:  freq_q  <= cfg_data_i[c2ut_pkg::FreqW-1:0];
        c2ut_pkg::REG_EPOCH: epoch_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      c2ut_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_d = (freq_q != '0) ? c2ut_pkg::ST_DIV_SEC : c2ut_pkg::ST_FIN;
        end
      end
      c2ut_pkg::ST_DIV_SEC: begin
        if (cnt_q == '1) state_d = c2ut_pkg::ST_SEC;
      end
      c2ut_pkg::ST_SEC:     state_d = c2ut_pkg::ST_DIV_US;
      c2ut_pkg::ST_DIV_US: begin
        if (cnt_q == '1) state_d = c2ut_pkg::ST_FIN;
      end
      c2ut_pkg::ST_FIN: begin
        if (!out_vld_q || out_if.ready) state_d = c2ut_pkg::ST_IDLE;
      end
      default:              state_d = c2ut_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_if.ready = 1'b0;
    div_step    = 1'b0;
    sec_step    = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      c2ut_pkg::ST_IDLE:    in_if.ready = 1'b1;
      c2ut_pkg::ST_DIV_SEC: div_step    = 1'b1;
      c2ut_pkg::ST_SEC:     sec_step    = 1'b1;
      c2ut_pkg::ST_DIV_US:  div_step    = 1'b1;
      c2ut_pkg::ST_FIN:     load_out    = !out_vld_q || out_if.ready;
      default: ;
    endcase
  end

  assign in_acc   = in_if.valid && in_if.ready;
  assign div_last = (state_q == c2ut_pkg::ST_DIV_US) && (cnt_q == '1);

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor where it fits
  assign shl  = {rem_q, num_q[c2ut_pkg::CountW-1]};
  assign diff = shl - {1'b0, freq_q};
  assign ge   = shl >= {1'b0, freq_q};
  // Remainder is below 2^32, so the scaled value fits in 52 bits
  assign prod = c2ut_pkg::ProdW'(rem_q) * c2ut_pkg::ProdW'(c2ut_pkg::UsecPerSec);

  // Datapath next values
  always_comb begin
    num_d      = num_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    ts_d       = ts_q;
    upd_d      = upd_q;
    held_sec_d = held_sec_q;
    held_us_d  = held_us_q;
    if (in_acc) begin
      ts_d  = in_if.counter_now;
      num_d = in_if.counter_now - boot_q;
      rem_d = '0;
      cnt_d = '0;
      upd_d = (freq_q != '0);
    end
    if (div_step) begin
      rem_d = ge ? diff[c2ut_pkg::FreqW-1:0] : shl[c2ut_pkg::FreqW-1:0];
      num_d = {num_q[c2ut_pkg::CountW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
    end
    if (sec_step) begin
      held_sec_d = epoch_q + num_q;
      num_d      = c2ut_pkg::CountW'(prod);
      rem_d      = '0;
    end
    // Quotient is below one million, so its low bits are the whole value
    if (div_last) held_us_d = num_d[c2ut_pkg::UsecW-1:0];
  end

  assign out_vld_d = load_out ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= c2ut_pkg::ST_IDLE;
      cnt_q      <= '0;
      upd_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      held_sec_q <= c2ut_pkg::EpochReset;
      held_us_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      upd_q      <= upd_d;
      out_vld_q  <= out_vld_d;
      held_sec_q <= held_sec_d;
      held_us_q  <= held_us_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    ts_q  <= ts_d;
    if (load_out) begin
      out_ts_q  <= ts_q;
      out_sec_q <= held_sec_q;
      out_us_q  <= held_us_q;
      out_upd_q <= upd_q;
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.timestamp     = out_ts_q;
  assign out_if.unix_seconds  = out_sec_q;
  assign out_if.micro_seconds = out_us_q;
  assign out_if.updated       = out_upd_q;

`ifndef SYNTHESIS
  // Held microseconds never reach a full second
  a_us_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_us_q < c2ut_pkg::UsecPerSec)
    else $error("held microseconds out of range");

  // The divider remainder stays below the divisor once the seconds are done
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == c2ut_pkg::ST_SEC |-> rem_q < freq_q)
    else $error("division remainder not below frequency");

  // A transaction with conversion disabled skips straight to the result
  a_zero_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && freq_q == '0 |=> state_q == c2ut_pkg::ST_FIN && !upd_q)
    else $error("zero frequency did not bypass the divider");

  // Held seconds change only in the seconds add step
  a_sec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != c2ut_pkg::ST_SEC |=> $stable(held_sec_q))
    else $error("held seconds changed outside the add step");
`endif

endmodule

// ===== tb/sv/c2ut_checker.sv =====
// Checker for the counter-to-unix-time converter: tracks registers, predicts results and compares.
module c2ut_checker
  import c2ut_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  c2ut_in_if                 in_ch,
  c2ut_out_if                out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output int                 mismatch_cnt_o,
  output int                 pending_cnt_o,
  output int                 checked_cnt_o,
  output int                 held_cnt_o
);

  typedef struct packed {
    logic [CountW-1:0] timestamp;
    logic [CountW-1:0] unix_seconds;
    logic [UsecW-1:0]  micro_seconds;
    logic              updated;
  } unix_time_t;

  unix_time_t expected_times [$];

  // Shadow copies of the block's registers and held time
  logic [CountW-1:0] boot_cnt;
  logic [FreqW-1:0]  tick_freq;
  logic [CountW-1:0] epoch_secs;
  logic [CountW-1:0] held_secs;
  logic [UsecW-1:0]  held_usec;

  int mismatches;
  int checked;
  int held;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    unix_time_t        want;
    unix_time_t        got;
    logic [CountW-1:0] elapsed;
    logic [CountW-1:0] rem;
    if (!rst_ni) begin
      boot_cnt   = '0;
      tick_freq  = '0;
      epoch_secs = EpochReset;
      held_secs  = EpochReset;
      held_usec  = '0;
      mismatches = 0;
      checked    = 0;
      held       = 0;
      expected_times.delete();
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
      checked_cnt_o  <= 0;
      held_cnt_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOOT:  boot_cnt   = cfg_data_i;
          REG_FREQ:  tick_freq  = cfg_data_i[FreqW-1:0];
          REG_EPOCH: epoch_secs = cfg_data_i;
          default: ;
        endcase
      end

      // Compare the result transaction with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.timestamp     = out_ch.timestamp;
        got.unix_seconds  = out_ch.unix_seconds;
        got.micro_seconds = out_ch.micro_seconds;
        got.updated       = out_ch.updated;
        if (expected_times.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: ts %h secs %h usec %0d upd %b", $realtime,
                     got.timestamp, got.unix_seconds, got.micro_seconds, got.updated);
          mismatches++;
        end else begin
          want = expected_times.pop_front();
          checked++;
          if (got !== want) begin
            if (mismatches < 10)
              $display({"[%0t] result %0d mismatch: ts %h/%h secs %h/%h usec %0d/%0d",
                        " upd %b/%b (expected/actual)"}, $realtime, checked,
                       want.timestamp, got.timestamp, want.unix_seconds, got.unix_seconds,
                       want.micro_seconds, got.micro_seconds, want.updated, got.updated);
            mismatches++;
          end
        end
      end

      // Predict the time for an accepted reading; hold the last one at zero frequency
      if (in_ch.valid && in_ch.ready) begin
        want.timestamp = in_ch.counter_now;
        if (tick_freq != '0) begin
          elapsed   = in_ch.counter_now - boot_cnt;
          rem       = elapsed % CountW'(tick_freq);
          held_secs = epoch_secs + elapsed / CountW'(tick_freq);
          held_usec = UsecW'((rem * CountW'(UsecPerSec)) / CountW'(tick_freq));
          want.updated = 1'b1;
        end else begin
          want.updated = 1'b0;
          held++;
        end
        want.unix_seconds  = held_secs;
        want.micro_seconds = held_usec;
        expected_times.push_back(want);
      end

      mismatch_cnt_o <= mismatches;
      pending_cnt_o  <= expected_times.size();
      checked_cnt_o  <= checked;
      held_cnt_o     <= held;
    end
  end

endmodule

// ===== tb/sv/counter_to_unix_time_tb.sv =====
// Testbench top for the counter-to-unix-time converter: stimulus, flow control and verdict.
module counter_to_unix_time_tb;
  import c2ut_pkg::*;

  // Index past the register list; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  // Long back-pressure stretch: several conversions' worth, so the block fills and stalls
  localparam int HoldCycles    = 800;
  // Longest quiet stretch is the hold plus one conversion; allow ample margin
  localparam int WatchdogLimit = 4000;
  // Settle time at the end of the run
  localparam int SettleCycles  = 300;
  localparam int RandomPhases  = 10;

  logic               clk;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CountW-1:0]  cfg_data;

  c2ut_in_if  in_ch ();
  c2ut_out_if out_ch ();

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int held_cnt;
  int stall_cycles;
  int sent_cnt;
  int settings_cnt;
  int fails;
  bit hold_off_req;

  counter_to_unix_time uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  c2ut_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .held_cnt_o     (held_cnt)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one counter reading after a random gap and hold it until the transaction
  // completes. With no gap, valid simply stays high for the next reading.
  task automatic push_reading(input logic [CountW-1:0] reading);
    int gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.counter_now <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.counter_now <= reading;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Write one register; lower the enable for a cycle so back-to-back writes never
  // put two assignments on it in one step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_clock(input logic [CountW-1:0] boot, input logic [CountW-1:0] freq_word,
                               input logic [CountW-1:0] epoch);
    write_reg(REG_BOOT, boot);
    write_reg(REG_FREQ, freq_word);
    write_reg(REG_EPOCH, epoch);
    settings_cnt++;
  endtask

  // Readings aimed at the interesting spots relative to the boot count: exact
  // seconds, largest remainder, above boot, just below it (elapsed wraps) and plain noise
  function automatic logic [CountW-1:0] pick_reading(input logic [CountW-1:0] boot,
                                                     input logic [FreqW-1:0] freq);
    logic [CountW-1:0] k;
    k = CountW'($urandom_range(0, 65535));
    case ($urandom_range(0, 4))
      0:       return {$urandom, $urandom};
      1:       return boot + CountW'($urandom);
      2:       return boot - CountW'($urandom_range(1, 1000));
      3:       return boot + k * CountW'(freq) + CountW'(freq) - 64'd1;
      default: return boot + k * CountW'(freq);
    endcase
  endfunction

  // Result side: random stalls per transaction, and one long hold-off on request
  initial begin : result_drain
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_ni) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        gap = $urandom_range(0, 14);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CountW-1:0] boot;
    logic [FreqW-1:0]  freq;
    logic [CountW-1:0] epoch;
    int                n_items;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_BOOT;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.counter_now <= '0;
    sent_cnt          = 0;
    settings_cnt      = 0;
    hold_off_req      = 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;

    // Frequency zero straight after reset: reset time held, not updated
    push_reading('0);
    push_reading('1);
    wait_drained();

    // One tick per second: seconds track the reading and wrap past 2^64
    program_clock('0, 64'd1, EpochReset);
    push_reading('0);
    push_reading(64'd1);
    push_reading('1);
    wait_drained();

    // Largest frequency, upper data bits set to check the 32-bit truncation
    program_clock('0, '1, '0);
    push_reading(64'h0000_0000_FFFF_FFFE);
    push_reading(64'h0000_0000_FFFF_FFFF);
    push_reading('1);
    wait_drained();

    // Boot at the top of the range: readings below it wrap; epoch at its maximum
    program_clock('1, 64'd1000000, '1);
    push_reading('0);
    push_reading(64'd5);
    push_reading('1);
    push_reading(64'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    // Spare index ignored; with frequency zero a new epoch must not touch the held time
    write_reg(CfgIdxSpare, '1);
    write_reg(REG_FREQ, '0);
    write_reg(REG_EPOCH, 64'd12345);
    settings_cnt++;
    push_reading(64'hDEAD_BEEF_0123_4567);
    push_reading('0);
    wait_drained();

    // Small odd frequency, remainder at its largest and just below boot
    program_clock(64'h8000_0000_0000_0000, 64'd3, EpochReset);
    push_reading(64'h8000_0000_0000_0002);
    push_reading(64'h7FFF_FFFF_FFFF_FFFF);
    push_reading('0);
    wait_drained();

    // Random settings, each with a batch of readings; one batch under long back-pressure
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 7))
        0:       freq = '0;
        1:       freq = 32'd1;
        2:       freq = '1;
        3:       freq = 32'd24000000;
        4:       freq = 32'($urandom_range(2, 1000));
        default: freq = 32'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       boot = '0;
        1:       boot = '1;
        default: boot = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 3))
        0:       epoch = EpochReset;
        1:       epoch = '1;
        2:       epoch = '1 - CountW'($urandom_range(0, 100000));
        default: epoch = {$urandom, $urandom};
      endcase
      program_clock(boot, {$urandom, freq}, epoch);
      if ($urandom_range(0, 1) != 0)
        write_reg(CfgIdxSpare, {$urandom, $urandom});
      if (p == 3)
        hold_off_req = 1'b1;
      n_items = $urandom_range(30, 50);
      for (int i = 0; i < n_items; i++)
        push_reading(pick_reading(boot, freq));
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);

    $display("Ran %0d counter readings over %0d register settings: %0d results checked,",
             sent_cnt, settings_cnt, checked_cnt);
    $display("%0d of them held at zero frequency, with one %0d-cycle output hold-off.",
             held_cnt, HoldCycles);
    fails = mismatch_cnt;
    if (pending_cnt != 0) begin
      $display("%0d predicted results never arrived", pending_cnt);
      fails = fails + pending_cnt;
    end
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/c2ut_pkg.sv
design/c2ut_if.sv
design/counter_to_unix_time.sv
tb/sv/c2ut_checker.sv
tb/sv/counter_to_unix_time_tb.sv
